/* rtl/dcp_pkg.sv */
// shared types for the distance constraint projection pipeline
// no dependencies
`default_nettype none

package dcp_pkg;

  // how the correction is split between the two particles
  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_BOTH,
    MOVE_A,
    MOVE_B
  } move_e;

  function automatic move_e move_mode(input logic pin_a, input logic pin_b);
    move_e m;
    if (!pin_a && !pin_b) begin
      m = MOVE_BOTH;
    end else if (!pin_a) begin
      m = MOVE_A;
    end else if (!pin_b) begin
      m = MOVE_B;
    end else begin
      m = MOVE_NONE;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/distance_constraint_projection_top.sv */
// distance constraint projection, fully pipelined
// depends on dcp_pkg (move mode type)
`default_nettype none

// usage
//   one word in: two 3d positions (signed fixed point), rest length and two
//   pinned flags. a word is taken at each rising edge where start is high
//   and busy is low; busy is always low, so a word may enter every cycle.
//   one word out per word in, in order, on the new_* ports with done_o high
//   for exactly one cycle. the receiver cannot stall and needs no handshake.
// throughput and stages
//   one word per cycle. the accepting edge loads the input register; the
//   word then passes through square, sum, COORD_WIDTH+1
//   square root stages (one root bit each), numerator multiply, COORD_WIDTH
//   divider stages (one quotient bit each, three lanes), output register.
// behavior
//   the offset d = b - a is scaled by rest/|d| with round to nearest; the
//   correction goes to a, b, split in half, or nowhere by the pinned flags.
//   when |d| floors to zero both positions pass through and degenerate_o
//   is set. outputs saturate to the signed coordinate range.
// reset
//   rst_ni clears the valid bits of every stage; words in flight are lost.

module distance_constraint_projection_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pos_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_z_i,
  input  logic        [COORD_WIDTH-2:0] rest_length_i,
  input  logic                          pinned_a_i,
  input  logic                          pinned_b_i,
  output logic signed [COORD_WIDTH-1:0] new_a_x_o,
  output logic signed [COORD_WIDTH-1:0] new_a_y_o,
  output logic signed [COORD_WIDTH-1:0] new_a_z_o,
  output logic signed [COORD_WIDTH-1:0] new_b_x_o,
  output logic signed [COORD_WIDTH-1:0] new_b_y_o,
  output logic signed [COORD_WIDTH-1:0] new_b_z_o,
  output logic                          degenerate_o,
  output logic                          done_o
);
  import dcp_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int MW  = CW + 1;       // offset magnitude, root width, sqrt steps
  localparam int SW  = 2 * MW;       // sum of squares
  localparam int RW  = MW + 2;       // sqrt remainder
  localparam int NW  = 2 * CW + 1;   // divider numerator
  localparam int QW  = CW;           // quotient bits, divider steps
  localparam int DW  = MW + 1;       // divisor 2*len
  localparam int DRW = CW + 3;       // divider remainder
  localparam int OW  = CW + 3;       // output sum before saturation

  typedef struct packed {
    logic [2:0][CW-1:0] a;
    logic [2:0][CW-1:0] b;
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
    logic [CW-2:0]      rest;
    move_e              mode;
  } side_t;

  function automatic logic [CW-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] hi;
    logic signed [OW-1:0] lo;
    logic [CW-1:0]        r;
    hi = OW'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = -hi - OW'(1);
    if (v > hi) begin
      r = hi[CW-1:0];
    end else if (v < lo) begin
      r = lo[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // input stage: offset and its magnitude
  logic [2:0][CW-1:0] in_a;
  logic [2:0][CW-1:0] in_b;
  side_t              p1_d;
  side_t              p1_q;
  logic               p1_val_q;

  assign in_a = {pos_a_z_i, pos_a_y_i, pos_a_x_i};
  assign in_b = {pos_b_z_i, pos_b_y_i, pos_b_x_i};

  always_comb begin
    logic [MW-1:0] dl;
    p1_d      = '0;
    p1_d.a    = in_a;
    p1_d.b    = in_b;
    p1_d.rest = rest_length_i;
    p1_d.mode = move_mode(pinned_a_i, pinned_b_i);
    for (int i = 0; i < 3; i++) begin
      dl = {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
      p1_d.neg[i] = dl[MW-1];
      p1_d.mag[i] = dl[MW-1] ? -dl : dl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_val_q <= 1'b0;
    end else begin
      p1_val_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
  end

  // squares
  logic [2:0][SW-1:0] p2_sq_q;
  side_t              p2_q;
  logic               p2_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_val_q <= 1'b0;
    end else begin
      p2_val_q <= p1_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q <= p1_q;
    for (int i = 0; i < 3; i++) begin
      p2_sq_q[i] <= p1_q.mag[i] * p1_q.mag[i];
    end
  end

  // sum of squares, feeds the root pipeline
  logic [SW-1:0] sr_s_q    [0:MW];
  logic [RW-1:0] sr_rem_q  [0:MW];
  logic [MW-1:0] sr_root_q [0:MW];
  side_t         sr_side_q [0:MW];
  logic [MW:0]   sr_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_val_q[0] <= 1'b0;
    end else begin
      sr_val_q[0] <= p2_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_s_q[0]    <= p2_sq_q[0] + p2_sq_q[1] + p2_sq_q[2];
    sr_rem_q[0]  <= '0;
    sr_root_q[0] <= '0;
    sr_side_q[0] <= p2_q;
  end

  // square root, one root bit per stage
  for (genvar j = 0; j < MW; j++) begin : g_sqrt
    logic [RW-1:0] rem_try;
    logic [RW-1:0] trial;
    logic          fits;

    assign rem_try = {sr_rem_q[j][RW-3:0], sr_s_q[j][SW-1:SW-2]};
    assign trial   = {sr_root_q[j], 2'b01};
    assign fits    = rem_try >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_val_q[j+1] <= 1'b0;
      end else begin
        sr_val_q[j+1] <= sr_val_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sr_s_q[j+1]    <= {sr_s_q[j][SW-3:0], 2'b00};
      sr_rem_q[j+1]  <= fits ? rem_try - trial : rem_try;
      sr_root_q[j+1] <= {sr_root_q[j][MW-2:0], fits};
      sr_side_q[j+1] <= sr_side_q[j];
    end
  end

  // numerator 2*|d_i|*rest + len per axis, divisor 2*len
  logic [2:0][NW-1:0] nm_d;
  logic [2:0][NW-1:0] nm_q;
  logic [DW-1:0]      nm_div_q;
  logic               nm_degen_q;
  side_t              nm_side_q;
  logic               nm_val_q;

  always_comb begin
    logic [MW+CW-2:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod    = sr_side_q[MW].mag[i] * sr_side_q[MW].rest;
      nm_d[i] = {prod, 1'b0} + NW'(sr_root_q[MW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_val_q <= 1'b0;
    end else begin
      nm_val_q <= sr_val_q[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q       <= nm_d;
    nm_div_q   <= {sr_root_q[MW], 1'b0};
    nm_degen_q <= sr_root_q[MW] == '0;
    nm_side_q  <= sr_side_q[MW];
  end

  // restoring divider, three lanes, one quotient bit per stage
  logic [2:0][DRW-1:0] dv_rem_q  [0:QW];
  logic [2:0][QW-1:0]  dv_lo_q   [0:QW];
  logic [2:0][QW-1:0]  dv_quo_q  [0:QW];
  logic [DW-1:0]       dv_div_q  [0:QW];
  logic [QW:0]         dv_degen_q;
  side_t               dv_side_q [0:QW];
  logic [QW:0]         dv_val_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] = DRW'(nm_q[i][NW-1:QW]);
      dv_lo_q[0][i]  = nm_q[i][QW-1:0];
      dv_quo_q[0][i] = '0;
    end
    dv_div_q[0]   = nm_div_q;
    dv_degen_q[0] = nm_degen_q;
    dv_side_q[0]  = nm_side_q;
    dv_val_q[0]   = nm_val_q;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [2:0][DRW-1:0] rem_try;
    logic [2:0]          fits;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_try[i] = {dv_rem_q[k][i][DRW-2:0], dv_lo_q[k][i][QW-1]};
        fits[i]    = rem_try[i] >= DRW'(dv_div_q[k]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_val_q[k+1] <= 1'b0;
      end else begin
        dv_val_q[k+1] <= dv_val_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[k+1][i] <= fits[i] ? rem_try[i] - DRW'(dv_div_q[k]) : rem_try[i];
        dv_lo_q[k+1][i]  <= {dv_lo_q[k][i][QW-2:0], 1'b0};
        dv_quo_q[k+1][i] <= {dv_quo_q[k][i][QW-2:0], fits[i]};
      end
      dv_div_q[k+1]   <= dv_div_q[k];
      dv_degen_q[k+1] <= dv_degen_q[k];
      dv_side_q[k+1]  <= dv_side_q[k];
    end
  end

  // apply correction, saturate, output register
  side_t              fin;
  logic [2:0][CW-1:0] na_d;
  logic [2:0][CW-1:0] nb_d;
  logic [2:0][CW-1:0] na_q;
  logic [2:0][CW-1:0] nb_q;
  logic               degen_q;
  logic               done_q;

  assign fin = dv_side_q[QW];

  always_comb begin
    logic signed [CW+1:0] cm;
    logic signed [CW+1:0] c;
    logic signed [CW+1:0] h;
    logic signed [OW-1:0] ae;
    logic signed [OW-1:0] be;
    logic signed [OW-1:0] ce;
    logic signed [OW-1:0] he;
    logic signed [OW-1:0] ra;
    logic signed [OW-1:0] rb;
    for (int i = 0; i < 3; i++) begin
      cm = signed'({1'b0, fin.mag[i]}) - signed'({2'b00, dv_quo_q[QW][i]});
      c  = fin.neg[i] ? -cm : cm;
      h  = c / 2;
      ae = OW'(signed'(fin.a[i]));
      be = OW'(signed'(fin.b[i]));
      ce = OW'(c);
      he = OW'(h);
      ra = ae;
      rb = be;
      if (!dv_degen_q[QW]) begin
        case (fin.mode)
          MOVE_BOTH: begin
            ra = ae + he;
            rb = be - he;
          end
          MOVE_A:  ra = ae + ce;
          MOVE_B:  rb = be - ce;
          default: ;
        endcase
      end
      na_d[i] = sat(ra);
      nb_d[i] = sat(rb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_val_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    na_q    <= na_d;
    nb_q    <= nb_d;
    degen_q <= dv_degen_q[QW];
  end

  assign new_a_x_o    = na_q[0];
  assign new_a_y_o    = na_q[1];
  assign new_a_z_o    = na_q[2];
  assign new_b_x_o    = nb_q[0];
  assign new_b_y_o    = nb_q[1];
  assign new_b_z_o    = nb_q[2];
  assign degenerate_o = degen_q;
  assign done_o       = done_q;

endmodule

`default_nettype wire

/* dv/dcp_checker.sv */
// checker for the distance constraint projection: predicts each result word
// from the accepted input word and compares it; depends on dcp_pkg
`timescale 1ns / 1ps

module dcp_checker #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pos_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_z_i,
  input  logic        [COORD_WIDTH-2:0] rest_length_i,
  input  logic                          pinned_a_i,
  input  logic                          pinned_b_i,
  input  logic signed [COORD_WIDTH-1:0] new_a_x_o,
  input  logic signed [COORD_WIDTH-1:0] new_a_y_o,
  input  logic signed [COORD_WIDTH-1:0] new_a_z_o,
  input  logic signed [COORD_WIDTH-1:0] new_b_x_o,
  input  logic signed [COORD_WIDTH-1:0] new_b_y_o,
  input  logic signed [COORD_WIDTH-1:0] new_b_z_o,
  input  logic                          degenerate_o,
  input  logic                          done_o,
  output int                            fail_count,
  output int                            pending,
  output int                            degen_seen
);
  import dcp_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz;
    logic   degen;
  } proj_t;

  proj_t projected_q[$];

  function automatic coord_t clamp(input logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[COORD_WIDTH-1:0];
    if (v < lo) return lo[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  // floor square root by bit-serial search
  function automatic logic [127:0] isqrt(input logic [127:0] s);
    logic [127:0] r, cand;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      cand = r | (128'd1 << k);
      if (cand * cand <= s) r = cand;
    end
    return r;
  endfunction

  function automatic proj_t project(input coord_t a[3], input coord_t b[3],
                                    input logic [COORD_WIDTH-2:0] rest,
                                    input logic pa, input logic pb);
    proj_t p;
    logic signed [127:0] d[3], c[3], na[3], nb[3], sc;
    logic [127:0] mag[3], sum, len, q;
    move_e mode;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = 128'(b[k]) - 128'(a[k]);
      mag[k] = d[k] < 0 ? -d[k] : d[k];
      sum += mag[k] * mag[k];
    end
    len = isqrt(sum);
    mode = move_mode(pa, pb);
    for (int k = 0; k < 3; k++) begin
      na[k] = a[k];
      nb[k] = b[k];
      if (len != 0) begin
        // round to nearest, ties away from zero
        q = (2 * mag[k] * rest + len) / (2 * len);
        sc = d[k] < 0 ? -$signed(q) : $signed(q);
        c[k] = d[k] - sc;
        case (mode)
          MOVE_BOTH: begin
            na[k] = a[k] + c[k] / 2;
            nb[k] = b[k] - c[k] / 2;
          end
          MOVE_A: na[k] = a[k] + c[k];
          MOVE_B: nb[k] = b[k] - c[k];
          default: ;
        endcase
      end
    end
    p.ax = clamp(na[0]); p.ay = clamp(na[1]); p.az = clamp(na[2]);
    p.bx = clamp(nb[0]); p.by = clamp(nb[1]); p.bz = clamp(nb[2]);
    p.degen = (len == 0);
    return p;
  endfunction

  always @(posedge clk_i) begin
    coord_t a[3], b[3];
    proj_t e, got;
    if (rst_ni) begin
      got = '{new_a_x_o, new_a_y_o, new_a_z_o, new_b_x_o, new_b_y_o, new_b_z_o,
              degenerate_o};
      if (done_o) begin
        if (projected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          e = projected_q.pop_front();
          if (e.degen) degen_seen++;
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp a=%0d %0d %0d b=%0d %0d %0d dg=%b",
                       e.ax, e.ay, e.az, e.bx, e.by, e.bz, e.degen);
              $display("          got a=%0d %0d %0d b=%0d %0d %0d dg=%b",
                       got.ax, got.ay, got.az, got.bx, got.by, got.bz, got.degen);
            end
          end
        end
      end
      if (start && !busy) begin
        a = '{pos_a_x_i, pos_a_y_i, pos_a_z_i};
        b = '{pos_b_x_i, pos_b_y_i, pos_b_z_i};
        projected_q.push_back(project(a, b, rest_length_i, pinned_a_i, pinned_b_i));
      end
    end
    pending = projected_q.size();
  end

  initial begin
    fail_count = 0;
    degen_seen = 0;
    pending = 0;
  end
endmodule

/* dv/distance_constraint_projection_top_tb.sv */
// stimulus and verdict for the distance constraint projection
// depends on dcp_checker and the block itself
`timescale 1ns / 1ps

module distance_constraint_projection_top_tb;
  localparam int CW = 32;
  localparam int LATENCY = 2 * CW + 6;
  localparam int LIMIT = 200000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic signed [CW-1:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
  logic [CW-2:0] rest = 0;
  logic pa = 0, pb = 0;
  logic signed [CW-1:0] nax, nay, naz, nbx, nby, nbz;
  logic degen, done;
  int fail_count, pending, degen_seen;
  int cycles = 0;
  int words_sent = 0;

  always #1 clk_i = ~clk_i;

  distance_constraint_projection_top #(.COORD_WIDTH(CW)) DUT (
    .clk_i, .rst_ni, .start, .busy,
    .pos_a_x_i(ax), .pos_a_y_i(ay), .pos_a_z_i(az),
    .pos_b_x_i(bx), .pos_b_y_i(by), .pos_b_z_i(bz),
    .rest_length_i(rest), .pinned_a_i(pa), .pinned_b_i(pb),
    .new_a_x_o(nax), .new_a_y_o(nay), .new_a_z_o(naz),
    .new_b_x_o(nbx), .new_b_y_o(nby), .new_b_z_o(nbz),
    .degenerate_o(degen), .done_o(done)
  );

  dcp_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk_i, .rst_ni, .start, .busy,
    .pos_a_x_i(ax), .pos_a_y_i(ay), .pos_a_z_i(az),
    .pos_b_x_i(bx), .pos_b_y_i(by), .pos_b_z_i(bz),
    .rest_length_i(rest), .pinned_a_i(pa), .pinned_b_i(pb),
    .new_a_x_o(nax), .new_a_y_o(nay), .new_a_z_o(naz),
    .new_b_x_o(nbx), .new_b_y_o(nby), .new_b_z_o(nbz),
    .degenerate_o(degen), .done_o(done),
    .fail_count, .pending, .degen_seen
  );

  // watchdog: a stuck pipeline ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random coordinate: full range, near zero, or near a base point
  function automatic logic signed [CW-1:0] rand_coord(input int mode,
                                                      input logic signed [CW-1:0] base);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
      default: return base + $signed($urandom_range(0, 2 ** 18)) - (2 ** 17);
    endcase
  endfunction

  // present one word, hold it until accepted, then optionally idle
  task automatic send_word(input logic signed [CW-1:0] a0, a1, a2, b0, b1, b2,
                           input logic [CW-2:0] r, input logic p0, p1,
                           input int gap);
    ax <= a0; ay <= a1; az <= a2; bx <= b0; by <= b1; bz <= b2;
    rest <= r; pa <= p0; pb <= p1;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    words_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int mode, gap;
    logic signed [CW-1:0] base, a0, a1, a2;
    logic [CW-2:0] r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: coinciding points, extremes, each pinned combination
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(5, -7, 9, 5, -7, 9, '1, 1, 1, 0);
    send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 100, 0, 1, 0);
    send_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 1);
    send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh80000000, '1, 0, 0, 0);
    send_word(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000,
              '1, 1, 0, 2);
    send_word(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, '1, 0, 1, 0);
    send_word(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    send_word(0, 0, 0, 1, 1, 1, '1, 0, 0, 0);
    send_word(0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 0);
    for (int k = 0; k < 4; k++)
      send_word(0, 0, 0, 32'sh30000, 32'sh40000, 0, 32'sh20000, k[1], k[0], 0);
    send_word(0, 0, 0, -32'sh30000, 0, 32'sh40000, 32'sh80000, 0, 0, 3);
    send_word(1, 2, 3, -1, -2, -3, 7, 0, 0, 0);

    // then let the pipeline drain completely before the random part
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // random: mostly nearby particle pairs with realistic rest lengths
    for (int n = 0; n < 540; n++) begin
      mode = $urandom_range(0, 9);
      base = rand_coord(0, 0);
      a0 = rand_coord(mode < 2 ? 0 : 1, base);
      a1 = rand_coord(mode < 2 ? 0 : 1, base);
      a2 = rand_coord(mode < 2 ? 0 : 1, base);
      r = ($urandom_range(0, 3) == 0) ? (CW-1)'($urandom)
                                      : (CW-1)'($urandom_range(0, 2 ** 19));
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      if (mode == 9)
        send_word(a0, a1, a2, a0, a1, a2, r, 1'($urandom), 1'($urandom), gap);
      else
        send_word(a0, a1, a2, rand_coord(mode < 2 ? 0 : 2, a0),
                  rand_coord(mode < 2 ? 0 : 2, a1), rand_coord(mode < 2 ? 0 : 2, a2),
                  r, 1'($urandom), 1'($urandom), gap);
      if (n == 270) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    // wait for the last words to leave the pipeline, plus margin
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d words, %0d with coinciding particles", words_sent, degen_seen);
    $display("random mix of full-range and nearby pairs, all pinned combinations");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/dcp_pkg.sv
rtl/distance_constraint_projection_top.sv
dv/dcp_checker.sv
dv/distance_constraint_projection_top_tb.sv
